// File: src/fm_chip_timer_register_port_unit_macros.svh
// Assertion macros shared by the timer register port RTL.
`ifndef FM_CHIP_TIMER_REGISTER_PORT_UNIT_MACROS_SVH
`define FM_CHIP_TIMER_REGISTER_PORT_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FMTMR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FMTMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fmtmr_pkg.sv
// Package with codes, register numbers and default tick lengths of the timer register port.
package fmtmr_pkg;

    // Request kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TIME  = 2'd2;

    // Port selects
    localparam logic [1:0] PORT_ADDR  = 2'd0;
    localparam logic [1:0] PORT_DATA  = 2'd1;
    localparam logic [1:0] PORT_ADDR3 = 2'd2;

    // Register numbers
    localparam int          REG_W     = 9;
    localparam logic [8:0]  REG_T1    = 9'h002;
    localparam logic [8:0]  REG_T2    = 9'h003;
    localparam logic [8:0]  REG_CTRL  = 9'h004;
    localparam logic [8:0]  REG_MODE  = 9'h105;
    localparam logic [8:0]  BANK_HIGH = 9'h100;

    // Control register bits
    localparam int CTRL_RESET_BIT  = 7;
    localparam int CTRL_MASK1_BIT  = 6;
    localparam int CTRL_MASK2_BIT  = 5;
    localparam int CTRL_START1_BIT = 0;
    localparam int CTRL_START2_BIT = 1;

    // Status byte
    localparam logic [7:0] STAT_ANY     = 8'h80;
    localparam logic [7:0] STAT_T1      = 8'h40;
    localparam logic [7:0] STAT_T2      = 8'h20;
    localparam logic [7:0] STAT_OPL3_RD = 8'hFF;

    // Timing
    localparam int CLOCK_W          = 64;
    localparam int ELAPSED_W        = 20;
    localparam int PRESET_SPAN      = 256;
    localparam int TIMER1_TICK_DEF  = 80;
    localparam int TIMER2_TICK_DEF  = 320;

endpackage

// File: src/fm_chip_timer_register_port_unit.sv
// FM chip timer register port: address latch, timer registers, status reads and clock.
//
// Usage: one request channel (in_valid/in_ready with kind, port, value, elapsed_us)
// and one result channel (out_valid/out_ready with read_data, fwd_valid, fwd_reg,
// fwd_value, opl3_mode). Every request yields exactly one result. Port writes latch a
// register number or update the timer presets and control register; other data writes
// come back as forwarded writes, and writes on the unused port code are dropped. Reads
// return the expired-timer status byte (0xFF on the OPL3 address port). Time requests
// advance the 64-bit microsecond clock. An accepted request is held in the input
// register; the state update runs between the input register and the result register,
// and the receiver takes the result from the result register. Throughput: one request
// per cycle while the receiver does not stall, set by the single state-update pass.
// Timer durations (256 - preset) * tick are multiplied at the input register so the
// update pass holds only one 64-bit add and compare per timer.
// Reset clears the clock, the timers, the address latch and the mode bit; both
// stages come up empty. When the receiver stalls, the result register holds, the
// input register holds one more request, and then in_ready drops.
`include "fm_chip_timer_register_port_unit_macros.svh"

module fm_chip_timer_register_port_unit #(
    parameter int TIMER1_TICK_US = fmtmr_pkg::TIMER1_TICK_DEF,
    parameter int TIMER2_TICK_US = fmtmr_pkg::TIMER2_TICK_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [1:0]                        port,
    input  logic [7:0]                        value,
    input  logic [fmtmr_pkg::ELAPSED_W-1:0]   elapsed_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        read_data,
    output logic                              fwd_valid,
    output logic [fmtmr_pkg::REG_W-1:0]       fwd_reg,
    output logic [7:0]                        fwd_value,
    output logic                              opl3_mode
);
    import fmtmr_pkg::*;

    localparam int DUR1_W = $clog2(PRESET_SPAN * TIMER1_TICK_US + 1);
    localparam int DUR2_W = $clog2(PRESET_SPAN * TIMER2_TICK_US + 1);
    localparam logic [DUR1_W-1:0] TICK1_C = DUR1_W'(TIMER1_TICK_US);
    localparam logic [DUR2_W-1:0] TICK2_C = DUR2_W'(TIMER2_TICK_US);
    localparam logic [DUR1_W-1:0] SPAN1_C = DUR1_W'(PRESET_SPAN);
    localparam logic [DUR2_W-1:0] SPAN2_C = DUR2_W'(PRESET_SPAN);
    localparam logic [DUR1_W-1:0] DUR1_RST = DUR1_W'(PRESET_SPAN * TIMER1_TICK_US);
    localparam logic [DUR2_W-1:0] DUR2_RST = DUR2_W'(PRESET_SPAN * TIMER2_TICK_US);

    // Input stage
    logic                  full_reg;
    logic [1:0]            kind_reg;
    logic [1:0]            port_reg;
    logic [7:0]            value_reg;
    logic [ELAPSED_W-1:0]  dt_reg;
    logic [DUR1_W-1:0]     dur1_in_reg;
    logic [DUR2_W-1:0]     dur2_in_reg;

    // Block state
    logic [REG_W-1:0]      addr_reg,   addr_next;
    logic [CLOCK_W-1:0]    now_reg,    now_next;
    logic [DUR1_W-1:0]     t1_dur_reg, t1_dur_next;
    logic [DUR2_W-1:0]     t2_dur_reg, t2_dur_next;
    logic                  t1_on_reg,  t1_on_next;
    logic                  t2_on_reg,  t2_on_next;
    logic [CLOCK_W-1:0]    t1_exp_reg, t1_exp_next;
    logic [CLOCK_W-1:0]    t2_exp_reg, t2_exp_next;
    logic                  mode_reg,   mode_next;

    // Result stage
    logic                  out_valid_reg;
    logic [7:0]            rd_reg,     rd_next;
    logic                  fv_reg,     fv_next;
    logic [REG_W-1:0]      fr_reg,     fr_next;
    logic [7:0]            fd_reg,     fd_next;

    logic                  out_free;
    logic                  fire;
    logic                  in_take;
    logic [DUR1_W-1:0]     t1_arm_dur;
    logic [DUR2_W-1:0]     t2_arm_dur;
    logic [CLOCK_W-1:0]    t1_arm_exp;
    logic [CLOCK_W-1:0]    t2_arm_exp;
    logic [7:0]            status;

    // Handshake: the update pass runs when a request waits and the result register is free
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = full_reg && out_free;
    assign in_ready = !full_reg || out_free;
    assign in_take  = in_valid && in_ready;

    // Capture the request and precompute both possible timer durations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg    <= kind;
            port_reg    <= port;
            value_reg   <= value;
            dt_reg      <= elapsed_us;
            dur1_in_reg <= (SPAN1_C - DUR1_W'(value)) * TICK1_C;
            dur2_in_reg <= (SPAN2_C - DUR2_W'(value)) * TICK2_C;
        end
    end

    // Pick the duration for a re-arm: the new preset on a preset write, else the stored one
    always_comb
    begin
        t1_arm_dur = (addr_reg == REG_T1) ? dur1_in_reg : t1_dur_reg;
        t2_arm_dur = (addr_reg == REG_T2) ? dur2_in_reg : t2_dur_reg;
    end

    assign t1_arm_exp = now_reg + CLOCK_W'(t1_arm_dur);
    assign t2_arm_exp = now_reg + CLOCK_W'(t2_arm_dur);

    // Form the status byte from the current timer state
    always_comb
    begin
        status = '0;
        if (t1_on_reg && (now_reg > t1_exp_reg))
        begin
            status = status | STAT_ANY | STAT_T1;
        end
        if (t2_on_reg && (now_reg > t2_exp_reg))
        begin
            status = status | STAT_ANY | STAT_T2;
        end
    end

    // Apply one request to the state and build its result
    always_comb
    begin
        addr_next   = addr_reg;
        now_next    = now_reg;
        t1_dur_next = t1_dur_reg;
        t2_dur_next = t2_dur_reg;
        t1_on_next  = t1_on_reg;
        t2_on_next  = t2_on_reg;
        t1_exp_next = t1_exp_reg;
        t2_exp_next = t2_exp_reg;
        mode_next   = mode_reg;
        rd_next     = '0;
        fv_next     = 1'b0;
        fr_next     = '0;
        fd_next     = '0;
        unique case (kind_reg)
            KIND_WRITE:
            begin
                unique case (port_reg)
                    PORT_ADDR:
                    begin
                        addr_next = REG_W'(value_reg);
                    end
                    PORT_ADDR3:
                    begin
                        addr_next = REG_W'(value_reg) | BANK_HIGH;
                    end
                    PORT_DATA:
                    begin
                        unique case (addr_reg)
                            REG_T1:
                            begin
                                t1_dur_next = dur1_in_reg;
                                if (t1_on_reg)
                                begin
                                    t1_exp_next = t1_arm_exp;
                                end
                            end
                            REG_T2:
                            begin
                                t2_dur_next = dur2_in_reg;
                                if (t2_on_reg)
                                begin
                                    t2_exp_next = t2_arm_exp;
                                end
                            end
                            REG_CTRL:
                            begin
                                if (value_reg[CTRL_RESET_BIT])
                                begin
                                    t1_on_next = 1'b0;
                                    t2_on_next = 1'b0;
                                end
                                else
                                begin
                                    if (!value_reg[CTRL_MASK1_BIT])
                                    begin
                                        t1_on_next = value_reg[CTRL_START1_BIT];
                                        if (value_reg[CTRL_START1_BIT])
                                        begin
                                            t1_exp_next = t1_arm_exp;
                                        end
                                    end
                                    if (!value_reg[CTRL_MASK2_BIT])
                                    begin
                                        t2_on_next = value_reg[CTRL_START2_BIT];
                                        if (value_reg[CTRL_START2_BIT])
                                        begin
                                            t2_exp_next = t2_arm_exp;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                if (addr_reg == REG_MODE)
                                begin
                                    mode_next = value_reg[0];
                                end
                                fv_next = 1'b1;
                                fr_next = addr_reg;
                                fd_next = value_reg;
                            end
                        endcase
                    end
                    default:
                    begin
                        // drop writes to the unused port code
                    end
                endcase
            end
            KIND_READ:
            begin
                rd_next = (port_reg == PORT_ADDR3) ? STAT_OPL3_RD : status;
            end
            KIND_TIME:
            begin
                now_next = now_reg + CLOCK_W'(dt_reg);
            end
            default:
            begin
                // unused kind code: result carries only the mode bit
            end
        endcase
    end

    // Advance the block state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            now_reg    <= '0;
            t1_dur_reg <= DUR1_RST;
            t2_dur_reg <= DUR2_RST;
            t1_on_reg  <= 1'b0;
            t2_on_reg  <= 1'b0;
            t1_exp_reg <= '0;
            t2_exp_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else if (fire)
        begin
            addr_reg   <= addr_next;
            now_reg    <= now_next;
            t1_dur_reg <= t1_dur_next;
            t2_dur_reg <= t2_dur_next;
            t1_on_reg  <= t1_on_next;
            t2_on_reg  <= t2_on_next;
            t1_exp_reg <= t1_exp_next;
            t2_exp_reg <= t2_exp_next;
            mode_reg   <= mode_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg <= rd_next;
            fv_reg <= fv_next;
            fr_reg <= fr_next;
            fd_reg <= fd_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = rd_reg;
    assign fwd_valid = fv_reg;
    assign fwd_reg   = fr_reg;
    assign fwd_value = fd_reg;
    assign opl3_mode = mode_reg;

    // Checks
    `FMTMR_ASSERT_NEXT(a_hold_pending, full_reg && !out_free, full_reg,
        "pending request lost while the result register was stalled")
    `FMTMR_ASSERT_SAME(a_fwd_quiet, out_valid_reg && !fv_reg, fr_reg == '0 && fd_reg == '0,
        "forwarded fields not cleared on a result without a forwarded write")
    `FMTMR_ASSERT_SAME(a_fwd_not_timer, out_valid_reg && fv_reg,
        fr_reg != REG_T1 && fr_reg != REG_T2 && fr_reg != REG_CTRL,
        "timer register write was forwarded")
    `FMTMR_ASSERT_SAME(a_mode_follow, out_valid_reg && fv_reg && fr_reg == REG_MODE,
        mode_reg == fd_reg[0],
        "mode bit does not match the forwarded mode register write")
    `FMTMR_ASSERT_SAME(a_status_form, out_valid_reg && rd_reg != '0 && rd_reg != STAT_OPL3_RD,
        rd_reg[7] && rd_reg[4:0] == '0 && !fv_reg,
        "malformed status byte")

endmodule

// File: bench/tb_fm_chip_timer_register_port_unit.sv
// Self-checking testbench for the FM chip timer register port: directed and random requests.
module tb_fm_chip_timer_register_port_unit;
    import fmtmr_pkg::*;

    // Request codes the block ignores or treats like a status read
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [1:0] PORT_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             fwd_valid;
        logic [REG_W-1:0] fwd_reg;
        logic [7:0]       fwd_value;
        logic             opl3_mode;
    } port_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [1:0]           port;
    logic [7:0]           value;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           read_data;
    logic                 fwd_valid;
    logic [REG_W-1:0]     fwd_reg;
    logic [7:0]           fwd_value;
    logic                 opl3_mode;

    // Shadow copy of the chip state
    logic [REG_W-1:0]     sel_reg;
    logic [CLOCK_W-1:0]   clock_us;
    logic [7:0]           t1_preset;
    logic                 t1_running;
    logic [CLOCK_W-1:0]   t1_due;
    logic [7:0]           t2_preset;
    logic                 t2_running;
    logic [CLOCK_W-1:0]   t2_due;
    logic                 mode_bit;

    port_result_t pending_results[$];
    int           mismatches;
    int           cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    fm_chip_timer_register_port_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .port       (port),
        .value      (value),
        .elapsed_us (elapsed_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .fwd_valid  (fwd_valid),
        .fwd_reg    (fwd_reg),
        .fwd_value  (fwd_value),
        .opl3_mode  (opl3_mode)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Expiry time of a timer started now with the given preset
    function automatic logic [CLOCK_W-1:0] expiry_at(input logic [7:0] preset, input int tick);
        return clock_us + 64'(PRESET_SPAN - int'(preset)) * 64'(tick);
    endfunction

    // Advance the shadow state by one request and queue the result it must produce
    task automatic apply_bus_request(input logic [1:0] k, input logic [1:0] p,
                                     input logic [7:0] v, input logic [ELAPSED_W-1:0] e);
        port_result_t r;
        r = '0;
        case (k)
            KIND_WRITE:
            begin
                if (p == PORT_ADDR)
                begin
                    sel_reg = {1'b0, v};
                end
                else if (p == PORT_ADDR3)
                begin
                    sel_reg = BANK_HIGH | {1'b0, v};
                end
                else if (p == PORT_DATA)
                begin
                    if (sel_reg == REG_T1)
                    begin
                        t1_preset = v;
                        if (t1_running)
                            t1_due = expiry_at(t1_preset, TIMER1_TICK_DEF);
                    end
                    else if (sel_reg == REG_T2)
                    begin
                        t2_preset = v;
                        if (t2_running)
                            t2_due = expiry_at(t2_preset, TIMER2_TICK_DEF);
                    end
                    else if (sel_reg == REG_CTRL)
                    begin
                        if (v[CTRL_RESET_BIT])
                        begin
                            t1_running = 1'b0;
                            t2_running = 1'b0;
                        end
                        else
                        begin
                            if (!v[CTRL_MASK1_BIT])
                            begin
                                t1_running = v[CTRL_START1_BIT];
                                if (t1_running)
                                    t1_due = expiry_at(t1_preset, TIMER1_TICK_DEF);
                            end
                            if (!v[CTRL_MASK2_BIT])
                            begin
                                t2_running = v[CTRL_START2_BIT];
                                if (t2_running)
                                    t2_due = expiry_at(t2_preset, TIMER2_TICK_DEF);
                            end
                        end
                    end
                    else
                    begin
                        if (sel_reg == REG_MODE)
                            mode_bit = v[0];
                        r.fwd_valid = 1'b1;
                        r.fwd_reg   = sel_reg;
                        r.fwd_value = v;
                    end
                end
            end
            KIND_READ:
            begin
                if (p == PORT_ADDR3)
                begin
                    r.read_data = STAT_OPL3_RD;
                end
                else
                begin
                    if (t1_running && clock_us > t1_due)
                        r.read_data = r.read_data | STAT_ANY | STAT_T1;
                    if (t2_running && clock_us > t2_due)
                        r.read_data = r.read_data | STAT_ANY | STAT_T2;
                end
            end
            KIND_TIME:
            begin
                clock_us = clock_us + 64'(e);
            end
            default:
            begin
            end
        endcase
        r.opl3_mode = mode_bit;
        pending_results.push_back(r);
    endtask

    // Drive one request from a falling edge and hold it until accepted
    task automatic send_request(input logic [1:0] k, input logic [1:0] p,
                                input logic [7:0] v, input logic [ELAPSED_W-1:0] e);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        kind       = k;
        port       = p;
        value      = v;
        elapsed_us = e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_bus_request(k, p, v, e);
        @(negedge clk);
    endtask

    // Address, data and forwarding paths, including the ignored codes
    task automatic test_register_routing();
        send_request(KIND_WRITE, PORT_ADDR3, 8'h05, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'hFF, '0);
        send_request(KIND_WRITE, PORT_NONE, 8'hAA, '0);
        send_request(KIND_NONE, PORT_NONE, 8'h55, '1);
        send_request(KIND_WRITE, PORT_ADDR3, 8'h02, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h5A, '0);
        send_request(KIND_WRITE, PORT_ADDR3, 8'h04, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h03, '0);
        send_request(KIND_WRITE, PORT_ADDR, 8'hFF, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h00, '0);
        send_request(KIND_WRITE, PORT_ADDR3, 8'h05, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'hFE, '0);
    endtask

    // Presets, control masks, expiry and status reads on every port
    task automatic test_timer_status();
        send_request(KIND_WRITE, PORT_ADDR, REG_T1[7:0], '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h00, '0);
        send_request(KIND_WRITE, PORT_ADDR, REG_T2[7:0], '0);
        send_request(KIND_WRITE, PORT_DATA, 8'hFF, '0);
        send_request(KIND_WRITE, PORT_ADDR, REG_CTRL[7:0], '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h03, '0);
        send_request(KIND_TIME, PORT_ADDR, 8'h00, '0);
        send_request(KIND_READ, PORT_ADDR, 8'h00, '0);
        send_request(KIND_TIME, PORT_DATA, 8'h00, 20'hFFFFF);
        send_request(KIND_READ, PORT_DATA, 8'h00, '0);
        send_request(KIND_READ, PORT_ADDR3, 8'h00, '0);
        send_request(KIND_READ, PORT_NONE, 8'h00, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h42, '0);
        send_request(KIND_READ, PORT_ADDR, 8'h00, '0);
        send_request(KIND_WRITE, PORT_DATA, 8'h80, '0);
        send_request(KIND_READ, PORT_ADDR, 8'h00, '0);
    endtask

    // Mostly address/data pairs aimed at the timer registers, with time and reads between
    task automatic test_random_traffic(input int count);
        int          issued;
        int          pick;
        logic [1:0]  k;
        logic [1:0]  p;
        logic [7:0]  v;
        logic [19:0] e;
        issued = 0;
        while (issued < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                p = PORT_ADDR;
                case ($urandom_range(0, 7))
                    0:       v = REG_T1[7:0];
                    1:       v = REG_T2[7:0];
                    2, 3:    v = REG_CTRL[7:0];
                    4:
                    begin
                        p = PORT_ADDR3;
                        v = REG_MODE[7:0];
                    end
                    5:
                    begin
                        p = PORT_ADDR3;
                        v = 8'($urandom_range(REG_T1, REG_CTRL));
                    end
                    default:
                    begin
                        p = $urandom_range(0, 1) ? PORT_ADDR3 : PORT_ADDR;
                        v = 8'($urandom);
                    end
                endcase
                send_request(KIND_WRITE, p, v, 20'($urandom));
                v = 8'($urandom);
                if ($urandom_range(0, 3) != 0)
                    v[CTRL_RESET_BIT] = 1'b0;
                send_request(KIND_WRITE, PORT_DATA, v, 20'($urandom));
                issued += 2;
            end
            else if (pick < 60)
            begin
                case ($urandom_range(0, 9))
                    0:       e = 20'($urandom);
                    1, 2, 3: e = 20'($urandom_range(0, 100000));
                    default: e = 20'($urandom_range(0, 3000));
                endcase
                send_request(KIND_TIME, 2'($urandom), 8'($urandom), e);
                issued += 1;
            end
            else if (pick < 85)
            begin
                send_request(KIND_READ, 2'($urandom), 8'($urandom), 20'($urandom));
                issued += 1;
            end
            else
            begin
                k = 2'($urandom);
                p = 2'($urandom);
                send_request(k, p, 8'($urandom), 20'($urandom));
                if (k != KIND_NONE && !(k == KIND_WRITE && p == PORT_NONE))
                    issued += 1;
            end
        end
    endtask

    // Stall the result side at the current rate
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge clk)
    begin
        port_result_t got;
        port_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{read_data, fwd_valid, fwd_reg, fwd_value, opl3_mode};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: rd=%h fwd=%b reg=%h val=%h mode=%b",
                             got.read_data, got.fwd_valid, got.fwd_reg, got.fwd_value,
                             got.opl3_mode);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data || got.fwd_valid !== want.fwd_valid ||
                    got.fwd_reg !== want.fwd_reg || got.fwd_value !== want.fwd_value ||
                    got.opl3_mode !== want.opl3_mode)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"mismatch: exp rd=%h fwd=%b reg=%h val=%h mode=%b,",
                                  " got rd=%h fwd=%b reg=%h val=%h mode=%b"},
                                 want.read_data, want.fwd_valid, want.fwd_reg,
                                 want.fwd_value, want.opl3_mode, got.read_data,
                                 got.fwd_valid, got.fwd_reg, got.fwd_value, got.opl3_mode);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_WRITE;
        port          = PORT_ADDR;
        value         = '0;
        elapsed_us    = '0;
        out_ready     = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 37;
        recv_idle_pct = 76;
        sel_reg       = '0;
        clock_us      = '0;
        t1_preset     = '0;
        t1_running    = 1'b0;
        t1_due        = '0;
        t2_preset     = '0;
        t2_running    = 1'b0;
        t2_due        = '0;
        mode_bit      = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_register_routing();
        test_timer_status();
        test_random_traffic(375);
        send_idle_pct = 76;
        recv_idle_pct = 37;
        test_random_traffic(375);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(375);
        in_valid = 1'b0;

        // Drain, then allow the pipeline to settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/fmtmr_pkg.sv
src/fm_chip_timer_register_port_unit.sv
bench/tb_fm_chip_timer_register_port_unit.sv
